>>> rtl/wam_pkg.sv
// Shared types and constants of the weekday alarm matcher.
package wam_pkg;

    localparam int NUM_ALARMS = 16;
    localparam int BEEP_CODES = 11;
    localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    localparam logic       FUNC_WRITE  = 1'b0;
    localparam logic       FUNC_TICK   = 1'b1;

    localparam logic [3:0] DAY_EACH    = 4'd7;
    localparam logic [3:0] DAY_ONCE    = 4'd8;
    localparam logic [3:0] DAY_WORK    = 4'd9;
    localparam logic [3:0] DAY_WEEKEND = 4'd10;

    localparam logic [6:0] MINUTE_NONE = 7'd127;
    localparam logic [3:0] BEEP_TOP    = 4'(BEEP_CODES - 1);
    localparam logic [4:0] ROUNDS_TOP  = 5'd20;

    typedef struct packed {
        logic       en;
        logic [3:0] day;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [1:0] pit;
        logic [3:0] bp;
    } wam_entry_t;

    localparam wam_entry_t ENTRY_DEFAULT = '{
        en:  1'b0,
        day: DAY_EACH,
        hr:  5'd0,
        mn:  6'd0,
        pit: 2'd1,
        bp:  4'd5
    };

    // Controller to datapath
    typedef struct packed {
        logic cap;
        logic decode;
        logic scan_step;
        logic decide;
        logic pend_step;
        logic load_out;
    } wam_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic dup;
        logic match_now;
        logic last;
        logic need_pend;
        logic out_free;
    } wam_stat_t;

endpackage

>>> rtl/weekday_alarm_matcher.sv
// Top level of the weekday alarm matcher: controller and datapath.
//
// Usage: the input channel (in_valid / in_stall) carries one word per item.
// func 0 writes one alarm entry (entry_index, entry_enabled, day_code, hour,
// minute, pitch, beep_code); func 1 is a minute tick carrying the current
// time and date. Every accepted word yields exactly one result word on the
// output channel (out_valid / out_stall): fire with the firing entry's
// index, pitch and beep setting, and the alarm_pending indicator.
// Timing: the weekday is worked out as the word is captured; a tick then
// walks the sixteen-entry table one entry a cycle until the first match,
// and a pending re-evaluation walks the whole table again. A write or a
// repeated minute goes straight to the result without a scan.
// One word is handled at a time; in_stall is high from accept until the
// result has been moved into the output register.
// Reset clears the table to its defaults (disabled, each day, pitch 1,
// five beeps), forgets the handled minute and the pending flag for the next result.
// A stalled receiver holds the result word steady; the block finishes the
// current word and then waits with the next one held off.
module weekday_alarm_matcher
    import wam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  entry_index,
    input  logic        entry_enabled,
    input  logic [3:0]  day_code,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [1:0]  pitch,
    input  logic [3:0]  beep_code,
    input  logic [5:0]  year,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fire,
    output logic [3:0]  fired_index,
    output logic [1:0]  fire_pitch,
    output logic        fire_short,
    output logic [4:0]  fire_rounds,
    output logic        alarm_pending
);

    wam_cmd_t  cmd;
    wam_stat_t stat;

    // sequencing: capture, scan, settle, re-evaluate, deliver
    wam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, weekday arithmetic and output register
    wam_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .entry_index   (entry_index),
        .entry_enabled (entry_enabled),
        .day_code      (day_code),
        .hour          (hour),
        .minute        (minute),
        .pitch         (pitch),
        .beep_code     (beep_code),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .fire          (fire),
        .fired_index   (fired_index),
        .fire_pitch    (fire_pitch),
        .fire_short    (fire_short),
        .fire_rounds   (fire_rounds),
        .alarm_pending (alarm_pending)
    );

endmodule

>>> rtl/wam_ctrl.sv
// Sequencing state machine of the weekday alarm matcher.
module wam_ctrl
    import wam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  wam_stat_t stat,
    output wam_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DECIDE,
        S_PEND,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.is_tick && !stat.dup)
                    state_next = S_SCAN;
                else
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.match_now || stat.last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.need_pend ? S_PEND : S_RESULT;
            end
            S_PEND:
            begin
                cmd.pend_step = 1'b1;
                if (stat.last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> rtl/wam_dp.sv
// Datapath of the weekday alarm matcher: alarm table, weekday, scan and result.
module wam_dp
    import wam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wam_cmd_t    cmd,
    output wam_stat_t   stat,
    input  logic        func,
    input  logic [3:0]  entry_index,
    input  logic        entry_enabled,
    input  logic [3:0]  day_code,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [1:0]  pitch,
    input  logic [3:0]  beep_code,
    input  logic [5:0]  year,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic        out_stall,
    output logic        out_valid,
    output logic        fire,
    output logic [3:0]  fired_index,
    output logic [1:0]  fire_pitch,
    output logic        fire_short,
    output logic [4:0]  fire_rounds,
    output logic        alarm_pending
);

    // 13*(m+1)/5 for the adjusted month range 3..15
    function automatic logic [5:0] month_term(input logic [4:0] m);
        logic [5:0] t;
        begin
            case (m)
                5'd3:    t = 6'd10;
                5'd4:    t = 6'd13;
                5'd5:    t = 6'd15;
                5'd6:    t = 6'd18;
                5'd7:    t = 6'd20;
                5'd8:    t = 6'd23;
                5'd9:    t = 6'd26;
                5'd10:   t = 6'd28;
                5'd11:   t = 6'd31;
                5'd12:   t = 6'd33;
                5'd13:   t = 6'd36;
                5'd14:   t = 6'd39;
                5'd15:   t = 6'd41;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

    function automatic logic [10:0] minutes_of(input logic [4:0] h, input logic [5:0] m);
        return (11'(h) << 6) - (11'(h) << 2) + 11'(m);
    endfunction

    // captured item
    logic       func_reg;
    logic [3:0] idx_reg;
    logic       en_reg;
    logic [3:0] day_reg;
    logic [4:0] hr_reg;
    logic [5:0] mn_reg;
    logic [1:0] pit_reg;
    logic [3:0] bp_reg;

    // table
    wam_entry_t            mem_reg [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] valid_reg;
    wam_entry_t            rd_entry;

    // scan state
    logic [IDX_W-1:0] cnt_reg;
    logic             hit_reg;
    logic             any_reg;
    logic [2:0]       wday_reg;
    logic [10:0]      now_reg;
    logic [6:0]       handled_reg;
    logic             pending_reg;

    // result
    logic             res_fire_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [1:0]       res_pit_reg;
    logic [3:0]       res_bp_reg;
    logic             out_valid_reg;

    // weekday arithmetic
    logic [4:0] m_adj;
    logic [6:0] y_adj;
    logic [9:0] wsum;
    logic [4:0] fold1;
    logic [3:0] fold2;
    logic [2:0] wday_calc;

    logic [2:0]  wday_inc;
    logic [10:0] a_min;
    logic        match_now;
    logic        pend_hit;
    logic        min12;

    always_comb
    begin
        if (month <= 4'd2)
        begin
            m_adj = 5'(month) + 5'd12;
            y_adj = 7'(year) + 7'd19;
        end
        else
        begin
            m_adj = 5'(month);
            y_adj = 7'(year) + 7'd20;
        end
        wsum  = 10'(day_of_month) + 10'(month_term(m_adj)) + 10'(y_adj)
              + 10'(y_adj >> 2) + 10'd523;
        // 8 is 1 mod 7: fold octal digits
        fold1 = 5'(wsum[2:0]) + 5'(wsum[5:3]) + 5'(wsum[8:6]) + 5'(wsum[9]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
        wday_calc = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    end

    assign rd_entry = valid_reg[cnt_reg] ? mem_reg[cnt_reg] : ENTRY_DEFAULT;
    assign wday_inc = (wday_reg == 3'd6) ? 3'd0 : wday_reg + 3'd1;
    assign a_min    = minutes_of(rd_entry.hr, rd_entry.mn);

    always_comb
    begin
        match_now = rd_entry.en && (rd_entry.mn == mn_reg) && (rd_entry.hr == hr_reg)
            && ((rd_entry.day == DAY_EACH) || (rd_entry.day == DAY_ONCE)
                || (rd_entry.day == {1'b0, wday_reg})
                || ((rd_entry.day == DAY_WORK) && (wday_reg < 3'd5))
                || ((rd_entry.day == DAY_WEEKEND) && (wday_reg >= 3'd5)));

        pend_hit = rd_entry.en
            && ((rd_entry.day == DAY_EACH) || (rd_entry.day == DAY_ONCE)
                || ((rd_entry.day == {1'b0, wday_reg}) && (a_min >= now_reg))
                || ((rd_entry.day == {1'b0, wday_inc}) && (a_min <= now_reg))
                || ((rd_entry.day == DAY_WORK)
                    && ((wday_reg < 3'd4)
                        || ((wday_reg == 3'd4) && (a_min >= now_reg))
                        || ((wday_reg == 3'd6) && (a_min <= now_reg))))
                || ((rd_entry.day == DAY_WEEKEND)
                    && ((wday_reg == 3'd5)
                        || ((wday_reg == 3'd6) && (a_min >= now_reg))
                        || ((wday_reg == 3'd4) && (a_min <= now_reg)))));

        min12 = (mn_reg inside {6'd0, 6'd12, 6'd24, 6'd36, 6'd48, 6'd60});
    end

    assign stat.is_tick   = (func_reg == FUNC_TICK);
    assign stat.dup       = (handled_reg == {1'b0, mn_reg});
    assign stat.match_now = match_now;
    assign stat.last      = (cnt_reg == IDX_W'(NUM_ALARMS - 1));
    assign stat.need_pend = hit_reg ? (rd_entry.day == DAY_ONCE) : min12;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            any_reg       <= 1'b0;
            handled_reg   <= MINUTE_NONE;
            pending_reg   <= 1'b0;
            res_fire_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
                res_fire_reg <= 1'b0;

            if (cmd.decode)
            begin
                if (func_reg == FUNC_WRITE)
                begin
                    if (32'(idx_reg) < NUM_ALARMS)
                        valid_reg[IDX_W'(idx_reg)] <= 1'b1;
                end
                else if (!stat.dup)
                begin
                    cnt_reg <= '0;
                    hit_reg <= 1'b0;
                end
            end

            if (cmd.scan_step)
            begin
                if (match_now)
                    hit_reg <= 1'b1;
                else if (!stat.last)
                    cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.decide)
            begin
                handled_reg  <= hit_reg ? {1'b0, mn_reg} : MINUTE_NONE;
                res_fire_reg <= hit_reg;
                // drop a one-time entry back to its defaults
                if (hit_reg && (rd_entry.day == DAY_ONCE))
                    valid_reg[cnt_reg] <= 1'b0;
                cnt_reg <= '0;
                any_reg <= 1'b0;
            end

            if (cmd.pend_step)
            begin
                any_reg <= any_reg | pend_hit;
                if (stat.last)
                    pending_reg <= any_reg | pend_hit;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload; the date fields are consumed through the weekday at capture time
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg  <= func;
            idx_reg   <= entry_index;
            en_reg    <= entry_enabled;
            day_reg   <= day_code;
            hr_reg    <= hour;
            mn_reg    <= minute;
            pit_reg   <= pitch;
            bp_reg    <= beep_code;
            wday_reg  <= wday_calc;
            now_reg   <= minutes_of(hour, minute);
        end

        if (cmd.decode && (func_reg == FUNC_WRITE) && (32'(idx_reg) < NUM_ALARMS))
            mem_reg[IDX_W'(idx_reg)] <= '{en: en_reg, day: day_reg, hr: hr_reg,
                                          mn: mn_reg, pit: pit_reg, bp: bp_reg};

        if (cmd.decide)
        begin
            res_idx_reg <= cnt_reg;
            res_pit_reg <= rd_entry.pit;
            res_bp_reg  <= rd_entry.bp;
        end

        if (cmd.load_out)
        begin
            fire          <= res_fire_reg;
            fired_index   <= res_fire_reg ? 4'(res_idx_reg) : 4'd0;
            fire_pitch    <= res_fire_reg ? res_pit_reg : 2'd0;
            fire_short    <= res_fire_reg && (res_bp_reg == 4'd0);
            fire_rounds   <= !res_fire_reg ? 5'd0
                           : (res_bp_reg == BEEP_TOP) ? ROUNDS_TOP : 5'(res_bp_reg);
            alarm_pending <= pending_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
